/* design/sine_tone_dds_unit_defines.svh */
// Assertion macros shared by the sine tone DDS checker.
`ifndef SINE_TONE_DDS_UNIT_DEFINES_SVH
`define SINE_TONE_DDS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define STDDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STDDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/stdds_pkg.sv */
// Types, constants and table functions for the sine tone DDS.
package stdds_pkg;

    localparam int FREQ_W   = 15;
    localparam int NOTE_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;

    typedef logic [FREQ_W-1:0]          freq_t;
    typedef logic signed [NOTE_W-1:0]   note_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [MAG_W-1:0]           mag_t;

    localparam int          SAMPLE_RATE     = 44100;
    localparam int          MAX_HZ          = 22050;
    localparam int          AMPLITUDE       = 32760;
    localparam int          BASE_FREQ_RESET = 169;
    localparam logic [63:0] HALF_PI_Q31     = 64'd3373259426;

    // Taylor divisors (2n)(2n+1); entry 0 unused.
    localparam int unsigned TAYLOR_DIV [20] = '{
        1, 6, 20, 42, 72, 110, 156, 210, 272, 342,
        420, 506, 600, 702, 812, 930, 1056, 1190, 1332, 1482
    };

    // sin(x) for x in [0, pi/2), argument and result unsigned Q31.
    function automatic logic [63:0] sin_q31(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        x2   = (x * x) >> 31;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (int n = 1; n < 20; n++) begin
            if (term != 64'd0) begin
                term = ((term * x2) >> 31) / 64'(TAYLOR_DIV[n]);
                if ((n % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
        end
        if (neg >= pos) begin
            return 64'd0;
        end
        pos = pos - neg;
        if (pos > (64'd1 << 31)) begin
            pos = 64'd1 << 31;
        end
        return pos;
    endfunction

    // Quarter-wave entry i of a table with 2^qbits entries.
    function automatic mag_t sine_entry(input int unsigned i, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        x = (HALF_PI_Q31 * 64'(i) + (64'd1 << (qbits - 1))) >> qbits;
        s = sin_q31(x);
        v = (64'(AMPLITUDE) * s + (64'd1 << 30)) >> 31;
        if (v > 64'(AMPLITUDE)) begin
            v = 64'(AMPLITUDE);
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

/* design/sine_tone_dds_unit.sv */
// Sine tone DDS top level: frequency clamp, increment multiply, phase add, table read.
// A result is registered in hz_reg, inc_reg, the table read and m_sample_reg in turn.
// Throughput: one sample per cycle unless stalled; only the stage 2 phase add is a loop.
// Reset: phase clears to 0 and base frequency to 169 Hz; the quarter-wave table is then
// loaded with 2^(TABLE_ADDR_BITS-2) entries (1024 by default) with s_ready held low.
// Configuration writes are taken at any time, including during the table load.
module sine_tone_dds_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  stdds_pkg::freq_t   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  stdds_pkg::note_t   s_note_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output stdds_pkg::sample_t m_sample
);
    import stdds_pkg::*;

    localparam int QUARTER_BITS  = TABLE_ADDR_BITS - 2;
    localparam int QUARTER_DEPTH = 1 << QUARTER_BITS;
    localparam int INC_W         = PHASE_BITS - 7;
    localparam int PROD_W        = PHASE_BITS + 8;
    localparam logic [63:0] INC_FULL =
        ((64'd1 << (PHASE_BITS + 8)) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
    localparam logic [INC_W-1:0] INC_PER_HZ = INC_FULL[INC_W-1:0];

    freq_t                   base_freq_reg;
    logic signed [17:0]      hz_sum;
    freq_t                   hz_next;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    m_valid_reg;
    logic                    en1;
    logic                    en2;
    logic                    en3;
    logic                    en_o;

    freq_t                   hz_reg;
    logic [PROD_W-1:0]       inc_product;
    logic [PHASE_BITS-1:0]   inc_reg;
    logic [PHASE_BITS-1:0]   phase_reg;

    logic [TABLE_ADDR_BITS-1:0] tab_addr;
    logic [1:0]              quadrant;
    logic [QUARTER_BITS-1:0] quarter_idx;
    logic [QUARTER_BITS:0]   mirror;
    logic [QUARTER_BITS-1:0] rom_addr;
    logic                    peak;
    logic                    neg_reg;
    logic                    peak_reg;

    logic                    fill_done;
    logic                    tbl_wr_en;
    logic [QUARTER_BITS-1:0] tbl_wr_addr;
    mag_t                    tbl_wr_data;
    logic                    tbl_rd_en;
    mag_t                    tbl_rd_data;

    mag_t                    mag;
    sample_t                 m_sample_next;
    sample_t                 m_sample_reg;

    // Stall chain: a stage moves when the next one is empty or moving.
    assign en_o    = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en_o;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = fill_done && en1;

    // Stage 0: saturate base + offset to 0..MAX_HZ.
    always_comb begin
        hz_sum = $signed({3'b000, base_freq_reg})
               + $signed({{2{s_note_offset[NOTE_W-1]}}, s_note_offset});
        if (hz_sum < 18'sd0) begin
            hz_next = '0;
        end else if (hz_sum > $signed(18'(MAX_HZ))) begin
            hz_next = FREQ_W'(MAX_HZ);
        end else begin
            hz_next = hz_sum[FREQ_W-1:0];
        end
    end

    // Stage 1: phase increment.
    assign inc_product = PROD_W'(hz_reg) * PROD_W'(INC_PER_HZ);

    // Stage 2: quadrant decode of the current phase.
    always_comb begin
        tab_addr    = phase_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        quadrant    = tab_addr[TABLE_ADDR_BITS-1 -: 2];
        quarter_idx = tab_addr[QUARTER_BITS-1:0];
        mirror      = (QUARTER_BITS+1)'(QUARTER_DEPTH) - {1'b0, quarter_idx};
        peak        = quadrant[0] && mirror[QUARTER_BITS];
        rom_addr    = quadrant[0] ? mirror[QUARTER_BITS-1:0] : quarter_idx;
    end

    assign tbl_rd_en = v2_reg && en3;

    // Stage 3: sign and peak override.
    always_comb begin
        mag = peak_reg ? MAG_W'(AMPLITUDE) : tbl_rd_data;
        if (neg_reg) begin
            m_sample_next = $signed(SAMPLE_W'(0) - {1'b0, mag});
        end else begin
            m_sample_next = $signed({1'b0, mag});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_freq_reg <= FREQ_W'(BASE_FREQ_RESET);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
            phase_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_freq_reg <= cfg_wr_data;
            end
            if (en1) begin
                v1_reg <= s_valid && fill_done;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en_o) begin
                m_valid_reg <= v3_reg;
            end
            if (tbl_rd_en) begin
                phase_reg <= phase_reg + inc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            hz_reg <= hz_next;
        end
        if (en2) begin
            inc_reg <= inc_product[PROD_W-1:8];
        end
        if (tbl_rd_en) begin
            neg_reg  <= quadrant[1];
            peak_reg <= peak;
        end
        if (en_o) begin
            m_sample_reg <= m_sample_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    stdds_table_fill #(
        .QUARTER_BITS(QUARTER_BITS)
    ) u_fill (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fill_done(fill_done),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_data  (tbl_wr_data)
    );

    stdds_ram #(
        .WIDTH(MAG_W),
        .DEPTH(QUARTER_DEPTH)
    ) u_sine_ram (
        .aclk   (aclk),
        .wr_en  (tbl_wr_en),
        .wr_addr(tbl_wr_addr),
        .wr_data(tbl_wr_data),
        .rd_en  (tbl_rd_en),
        .rd_addr(rom_addr),
        .rd_data(tbl_rd_data)
    );

endmodule

/* design/stdds_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module stdds_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/stdds_table_fill.sv */
// Post-reset loader that sweeps the quarter-wave sine contents into the table RAM.
module stdds_table_fill #(
    parameter int QUARTER_BITS = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    output logic                     fill_done,
    output logic                     wr_en,
    output logic [QUARTER_BITS-1:0]  wr_addr,
    output stdds_pkg::mag_t          wr_data
);
    import stdds_pkg::*;

    localparam int QUARTER_DEPTH = 1 << QUARTER_BITS;

    mag_t                    sine_lut [QUARTER_DEPTH];
    logic [QUARTER_BITS:0]   fill_cnt_reg;
    logic                    wr_en_reg;
    logic [QUARTER_BITS-1:0] wr_addr_reg;
    mag_t                    wr_data_reg;

    for (genvar gi = 0; gi < QUARTER_DEPTH; gi++) begin : g_lut
        assign sine_lut[gi] = sine_entry(gi, QUARTER_BITS);
    end

    assign fill_done = fill_cnt_reg[QUARTER_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
            wr_en_reg    <= 1'b0;
        end else begin
            wr_en_reg <= !fill_done;
            if (!fill_done) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= fill_cnt_reg[QUARTER_BITS-1:0];
        wr_data_reg <= sine_lut[fill_cnt_reg[QUARTER_BITS-1:0]];
    end

    assign wr_en   = wr_en_reg;
    assign wr_addr = wr_addr_reg;
    assign wr_data = wr_data_reg;

endmodule

/* design/stdds_checker.sv */
// Port-level checker for the sine tone DDS, bound to the top level.
`include "sine_tone_dds_unit_defines.svh"

module stdds_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input stdds_pkg::sample_t m_sample
);
    import stdds_pkg::*;

    // Held result must not change until its transfer.
    `STDDS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample), "stalled sample changed")

    // Samples stay within the sine amplitude.
    `STDDS_ASSERT_NOW(a_out_range, aclk, aresetn, m_valid, (m_sample >= -sample_t'(AMPLITUDE)) && (m_sample <= sample_t'(AMPLITUDE)), "sample out of amplitude range")

    // Right after reset the table is loading and nothing is pending.
    `STDDS_ASSERT_NOW(a_reset_quiet, aclk, aresetn, $past(!aresetn), !s_ready && !m_valid, "activity right after reset")

endmodule

bind sine_tone_dds_unit stdds_checker u_checker (.*);
